// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/pvp_pkg.sv =====
// Types and constants of the point view projection block.
// Depends on nothing.
package pvp_pkg;
   localparam int unsigned STORE_DEPTH = 28;
   localparam int unsigned PROJ_BASE   = 12;
   localparam logic        OP_WRITE    = 1'b0;
   localparam logic        OP_PROJECT  = 1'b1;
   localparam logic [1:0]  MODE_NONE   = 2'd0;
   localparam logic [1:0]  MODE_PERSP  = 2'd1;
   localparam logic [1:0]  MODE_GENERAL = 2'd2;
   localparam logic        CSR_MODE    = 1'b0;
   localparam logic        CSR_FOCUS   = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [4:0]         coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               divide_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRITE, ST_MAC, ST_MAC_WAIT, ST_ROW_DONE, ST_DIV_START,
      ST_DIV_RUN, ST_DIV_DONE, ST_FINISH, ST_INIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;        // capture request
      logic       write_coef;  // write coefficient store
      logic       init_write;  // identity load after reset, address on coef_addr
      logic       init_one;    // identity load word is 1.0
      logic       clear_acc;   // clear accumulator
      logic       mac;         // multiply-accumulate term
      logic [4:0] coef_addr;   // store address being read
      logic [1:0] term;        // 0..3 operand select
      logic       src_view;    // operands from point (1) or view result (0)
      logic [1:0] row_dest;    // destination of finished row
      logic       row_proj;    // row result written to projection regs
      logic       div_start;
      logic [1:0] div_sel;     // which quotient
      logic       div_store;
   } ctl_type;

   typedef struct packed {
      logic div_busy;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction
endpackage

// ===== src/pvp_ram.sv =====
// Generic single-port-write RAM with registered read.
// Depends on nothing.
module pvp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 28
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read a word
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== src/pvp_div.sv =====
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
// Depends on nothing.
module pvp_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [32:0] den,
   output logic               busy,
   output logic [63:0]        quot_mag,
   output logic               quot_neg
);
   logic [63:0] q_ff, q_in;
   logic [64:0] r_ff, r_in;
   logic [32:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [64:0] trial;
   logic [63:0] nabs;

   always_comb begin
      nabs   = num[63] ? 64'(-num) : 64'(num);
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      trial  = {r_ff[63:0], q_ff[63]} - {32'd0, d_ff};
      if (start) begin
         q_in   = nabs;
         r_in   = '0;
         d_in   = den[32] ? 33'(-den) : 33'(den);
         neg_in = num[63] ^ den[32];
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         // shift one bit, subtract when it fits
         if (!trial[64]) begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[63:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end
   assign busy     = cnt_ff != 7'd0;
   assign quot_mag = q_ff;
   assign quot_neg = neg_ff;
endmodule

// ===== src/pvp_datapath.sv =====
// Datapath: coefficient store, multiply-accumulate unit, divider, result.
// Depends on pvp_pkg, pvp_ram and pvp_div.
module pvp_datapath #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  pvp_pkg::req_type   req,
   input  pvp_pkg::ctl_type   ctl,
   input  logic [1:0]         mode,
   input  logic signed [31:0] focus,
   output pvp_pkg::sts_type   sts,
   output pvp_pkg::rsp_type   rsp_data
);
   import pvp_pkg::*;

   req_type            req_ff;
   logic signed [31:0] coef_rd;
   logic signed [31:0] v_ff [3];
   logic signed [31:0] h_ff [4];
   logic signed [31:0] opnd_ff, opnd_in;
   logic               mac_ff;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [63:0] prod_sh;
   logic signed [63:0] num;
   logic signed [32:0] den;
   logic               div_busy;
   logic [63:0]        qmag;
   logic               qneg;
   logic signed [31:0] qsat;
   logic signed [31:0] r_ff [3];
   logic               err_ff;
   logic signed [31:0] sel_num;
   logic signed [31:0] one_coord;
   logic signed [31:0] one_coef;
   logic [31:0]        wr_data;
   logic [4:0]         wr_addr;

   assign one_coord = 32'(64'sd1 <<< COORD_FRAC_BITS);
   assign one_coef  = 32'(64'sd1 <<< COEF_FRAC_BITS);

   // identity load after reset, else the requested coefficient write
   assign wr_addr = ctl.init_write ? ctl.coef_addr : req_ff.coef_index;
   assign wr_data = ctl.init_write ? (ctl.init_one ? one_coef : 32'd0) : req_ff.coef_value;

   pvp_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
      .clock(clock), .wr_en(ctl.write_coef || ctl.init_write), .wr_addr(wr_addr),
      .wr_data(wr_data), .rd_addr(ctl.coef_addr), .rd_data(coef_rd));

   // pick the operand for this term; it lines up with the registered read
   always_comb begin
      case (ctl.term)
         2'd0: opnd_in = ctl.src_view ? req_ff.point_x : v_ff[0];
         2'd1: opnd_in = ctl.src_view ? req_ff.point_y : v_ff[1];
         2'd2: opnd_in = ctl.src_view ? req_ff.point_z : v_ff[2];
         default: opnd_in = one_coord;
      endcase
   end

   // product with floor shift, then accumulate exactly
   assign prod_sh = (64'(coef_rd) * 64'(opnd_ff)) >>> COEF_FRAC_BITS;
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear_acc) acc_in = '0;
      else if (mac_ff) acc_in = acc_ff + 66'(prod_sh);
   end

   // divider operands
   always_comb begin
      case (ctl.div_sel)
         2'd0: sel_num = (mode == MODE_PERSP) ? v_ff[0] : h_ff[0];
         2'd1: sel_num = (mode == MODE_PERSP) ? v_ff[1] : h_ff[1];
         default: sel_num = h_ff[2];
      endcase
      if (mode == MODE_PERSP) begin
         num = 64'(sel_num) * 64'(focus);
         den = 33'(focus) - 33'(v_ff[2]);
      end else begin
         num = 64'(sel_num) <<< COORD_FRAC_BITS;
         den = 33'(h_ff[3]);
      end
   end

   pvp_div u_div (.clock(clock), .reset(reset), .start(ctl.div_start), .num(num),
      .den(den), .busy(div_busy), .quot_mag(qmag), .quot_neg(qneg));

   // saturate the quotient or the zero-divisor case
   always_comb begin
      if (den == 33'sd0)
         qsat = (num > 0) ? 32'sh7FFF_FFFF : ((num < 0) ? 32'sh8000_0000 : 32'sd0);
      else if (qneg)
         qsat = (qmag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-qmag);
      else
         qsat = (qmag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(qmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         mac_ff <= ctl.mac;
         if (ctl.load) err_ff <= 1'b0;
         else if (ctl.div_store && den == 33'sd0) err_ff <= 1'b1;
      end
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
      if (ctl.load) req_ff <= req;
      // store a finished row
      if (ctl.row_dest != 2'd3 || ctl.row_proj) begin
         if (ctl.row_proj) h_ff[ctl.term] <= sat32(acc_ff);
         else v_ff[ctl.row_dest] <= sat32(acc_ff);
      end
      if (ctl.div_store) r_ff[ctl.div_sel] <= qsat;
   end

   // assemble the result word
   always_comb begin
      rsp_data = '0;
      if (req_ff.opcode == OP_PROJECT) begin
         case (mode)
            MODE_PERSP: begin
               rsp_data.out_x = r_ff[0];
               rsp_data.out_y = r_ff[1];
               rsp_data.out_z = v_ff[2];
               rsp_data.divide_error = err_ff;
            end
            MODE_GENERAL: begin
               rsp_data.out_x = r_ff[0];
               rsp_data.out_y = r_ff[1];
               rsp_data.out_z = r_ff[2];
               rsp_data.divide_error = err_ff;
            end
            default: begin
               rsp_data.out_x = v_ff[0];
               rsp_data.out_y = v_ff[1];
               rsp_data.out_z = v_ff[2];
            end
         endcase
      end
   end
   assign sts.div_busy = div_busy;
endmodule

// ===== src/pvp_ctrl.sv =====
// Controller: sequences the row products, divisions and the result strobe.
// Depends on pvp_pkg.
module pvp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pvp_pkg::req_type req,
   input  logic [1:0]       mode,
   input  pvp_pkg::sts_type sts,
   output pvp_pkg::ctl_type ctl,
   output logic             busy,
   output logic             done
);
   import pvp_pkg::*;

   state_type  state_ff, state_in;
   logic [4:0] row_ff, row_in;     // 0..6: three view rows then four projection rows; store address in ST_INIT
   logic [2:0] term_ff, term_in;   // read address issue counter 0..4
   logic       wlegal_ff, wlegal_in;
   logic [1:0] dsel_ff, dsel_in;
   logic [1:0] last_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff <= '0; term_ff <= '0; wlegal_ff <= 1'b0; dsel_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in; term_ff <= term_in; wlegal_ff <= wlegal_in;
         dsel_ff <= dsel_in;
      end
   end

   assign last_div = (mode == MODE_GENERAL) ? 2'd2 : 2'd1;

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      term_in   = term_ff;
      wlegal_in = wlegal_ff;
      dsel_in   = dsel_ff;
      ctl       = '0;
      ctl.row_dest = 2'd3;
      ctl.src_view = row_ff < 5'd3;
      ctl.div_sel  = dsel_ff;
      busy = state_ff != ST_IDLE;
      done = 1'b0;
      ctl.coef_addr = 5'((row_ff < 5'd3 ? row_ff * 5'd4 : 5'd12 + (row_ff - 5'd3) * 5'd4)
                         + 5'(term_ff[1:0]));
      ctl.term = term_ff[1:0];
      case (state_ff)
         // load the identity matrices into the store, one word a cycle
         ST_INIT: begin
            ctl.init_write = 1'b1;
            ctl.coef_addr = row_ff;
            ctl.init_one = row_ff == 5'd0 || row_ff == 5'd5 || row_ff == 5'd10 ||
                           row_ff == 5'(PROJ_BASE) || row_ff == 5'(PROJ_BASE + 5) ||
                           row_ff == 5'(PROJ_BASE + 10) || row_ff == 5'(PROJ_BASE + 15);
            row_in = row_ff + 5'd1;
            if (row_ff == 5'(STORE_DEPTH - 1)) begin
               row_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               wlegal_in = req.coef_index < 5'(STORE_DEPTH);
               row_in = '0; term_in = '0; dsel_in = '0;
               state_in = (req.opcode == OP_WRITE) ? ST_WRITE : ST_MAC;
            end
         end
         ST_WRITE: begin
            ctl.write_coef = wlegal_ff;
            state_in = ST_FINISH;
         end
         // issue four reads; each multiply follows in the cycle after its read
         ST_MAC: begin
            if (term_ff == 3'd0) ctl.clear_acc = 1'b1;
            ctl.mac = 1'b1;
            term_in = term_ff + 3'd1;
            if (term_ff == 3'd3) state_in = ST_MAC_WAIT;
         end
         ST_MAC_WAIT: begin
            ctl.term = 2'd3;
            state_in = ST_ROW_DONE;
         end
         ST_ROW_DONE: begin
            if (row_ff < 5'd3) ctl.row_dest = row_ff[1:0];
            else begin
               ctl.row_proj = 1'b1;
               ctl.term = 2'(row_ff - 5'd3);
            end
            term_in = '0;
            row_in = row_ff + 5'd1;
            if ((row_ff == 5'd2 && mode != MODE_GENERAL) || row_ff == 5'd6)
               state_in = (mode == MODE_PERSP || mode == MODE_GENERAL) ?
                          ST_DIV_START : ST_FINISH;
            else state_in = ST_MAC;
         end
         ST_DIV_START: begin
            ctl.div_start = 1'b1;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!sts.div_busy) state_in = ST_DIV_DONE;
         end
         ST_DIV_DONE: begin
            ctl.div_store = 1'b1;
            dsel_in = dsel_ff + 2'd1;
            state_in = (dsel_ff == last_div) ? ST_FINISH : ST_DIV_START;
         end
         ST_FINISH: begin
            done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== src/point_view_projection.sv =====
// Top level of the point view projection block: CSR port, controller, datapath.
// Depends on pvp_pkg, pvp_ctrl and pvp_datapath.
//
//  channel  | handshake              | word
//  req_     | start high, busy low   | pvp_pkg::req_type
//  rsp_     | rsp_strobe, one cycle  | pvp_pkg::rsp_type
//  csr_     | APB write/read         | mode, focus_distance
//
// A coefficient write runs from acceptance through ST_WRITE to the strobe in ST_FINISH.
// A point takes each matrix row in turn on the one shared multiply-accumulate unit,
// then, with projection, one division per quotient on the bit-serial divider
// (two in perspective; three in general mode after four more rows).
// After reset a pass loads the identity matrices into the store, one word per
// address, while busy stays high; the receiver cannot stall.
module point_view_projection #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pvp_pkg::req_type req_word,
   output logic             rsp_strobe,
   output pvp_pkg::rsp_type rsp_word,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import pvp_pkg::*;

   logic [1:0]         mode_ff;
   logic signed [31:0] focus_ff;
   ctl_type            ctl;
   sts_type            sts;
   logic               done;

   assign pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NONE;
         focus_ff <= '0;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         if (paddr[2] == CSR_MODE) mode_ff <= pwdata[1:0];
         else focus_ff <= pwdata;
      end
   end
   assign prdata = (paddr[2] == CSR_FOCUS) ? focus_ff : {30'd0, mode_ff};

   pvp_ctrl u_ctrl (.clock(clock), .reset(reset), .start(start), .req(req_word),
      .mode(mode_ff), .sts(sts), .ctl(ctl), .busy(busy), .done(done));

   pvp_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS))
   u_dp (.clock(clock), .reset(reset), .req(req_word), .ctl(ctl), .mode(mode_ff),
      .focus(focus_ff), .sts(sts), .rsp_data(rsp_word));

   assign rsp_strobe = done;
endmodule

// ===== src/pvp_checker.sv =====
// Port-level checker for the point view projection block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module pvp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `ASSERT_NEXT(a_strobe_idle, clock, reset, rsp_strobe, !busy && !rsp_strobe)
endmodule

bind point_view_projection pvp_checker u_pvp_checker (.clock(clock), .reset(reset),
   .start(start), .busy(busy), .rsp_strobe(rsp_strobe));

// ===== tb/tb_top.sv =====
// Self-checking testbench of point_view_projection: directed and random words
// checked against an in-bench predictor of the view transform and projection.
// Depends on pvp_pkg and the point_view_projection RTL.
`timescale 1ns / 1ps

module tb_top;
   import pvp_pkg::*;

   localparam int unsigned COORD_FRAC = 16;
   localparam int unsigned COEF_FRAC  = 24;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam logic [31:0] ONE_COEF = 32'h0100_0000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_word;
   logic        rsp_strobe;
   rsp_type     rsp_word;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // predictor state
   logic [31:0] coef_mem [STORE_DEPTH];
   logic [1:0]  view_mode;
   logic [31:0] focus;
   rsp_type     expected_words [$];
   int unsigned mismatches;
   int unsigned cycles;

   point_view_projection uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // saturate to signed 32 bits
   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   // one matrix row times (a, b, c, 1.0)
   function automatic logic signed [63:0] row_sum(input int unsigned base,
      input logic signed [63:0] a, input logic signed [63:0] b,
      input logic signed [63:0] c);
      logic signed [63:0] k0, k1, k2, k3, s;
      k0 = {{32{coef_mem[base][31]}}, coef_mem[base]};
      k1 = {{32{coef_mem[base+1][31]}}, coef_mem[base+1]};
      k2 = {{32{coef_mem[base+2][31]}}, coef_mem[base+2]};
      k3 = {{32{coef_mem[base+3][31]}}, coef_mem[base+3]};
      s = ((k0 * a) >>> COEF_FRAC) + ((k1 * b) >>> COEF_FRAC)
        + ((k2 * c) >>> COEF_FRAC) + ((k3 * (64'sd1 <<< COORD_FRAC)) >>> COEF_FRAC);
      return clamp32(s);
   endfunction

   // truncating divide, saturated; zero divisor flags and saturates to sign
   function automatic logic signed [63:0] quotient(input logic signed [63:0] num,
      input logic signed [63:0] den, inout logic err);
      if (den == 0) begin
         err = 1'b1;
         if (num > 0) return 64'sh7FFF_FFFF;
         if (num < 0) return -64'sh8000_0000;
         return 0;
      end
      return clamp32(num / den);
   endfunction

   // work out the result of one accepted word and update the store
   function automatic rsp_type project_word(input req_type w);
      rsp_type r;
      logic signed [63:0] px, py, pz, tx, ty, tz, f, hx, hy, hz, hw;
      logic err;
      r = '0;
      err = 1'b0;
      if (w.opcode == OP_WRITE) begin
         if (w.coef_index < STORE_DEPTH) coef_mem[w.coef_index] = w.coef_value;
         return r;
      end
      px = w.point_x;
      py = w.point_y;
      pz = w.point_z;
      tx = row_sum(0, px, py, pz);
      ty = row_sum(4, px, py, pz);
      tz = row_sum(8, px, py, pz);
      if (view_mode == MODE_PERSP) begin
         f = $signed(focus);
         r.out_x = 32'(quotient(tx * f, f - tz, err));
         r.out_y = 32'(quotient(ty * f, f - tz, err));
         r.out_z = tz[31:0];
      end else if (view_mode == MODE_GENERAL) begin
         hx = row_sum(PROJ_BASE, tx, ty, tz);
         hy = row_sum(PROJ_BASE + 4, tx, ty, tz);
         hz = row_sum(PROJ_BASE + 8, tx, ty, tz);
         hw = row_sum(PROJ_BASE + 12, tx, ty, tz);
         r.out_x = 32'(quotient(hx <<< COORD_FRAC, hw, err));
         r.out_y = 32'(quotient(hy <<< COORD_FRAC, hw, err));
         r.out_z = 32'(quotient(hz <<< COORD_FRAC, hw, err));
      end else begin
         r.out_x = tx[31:0];
         r.out_y = ty[31:0];
         r.out_z = tz[31:0];
      end
      r.divide_error = err;
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got,
      input logic [31:0] want);
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            report("unexpected word, out_x", rsp_word.out_x, 32'h0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.out_x !== want.out_x) report("out_x", rsp_word.out_x, want.out_x);
            if (rsp_word.out_y !== want.out_y) report("out_y", rsp_word.out_y, want.out_y);
            if (rsp_word.out_z !== want.out_z) report("out_z", rsp_word.out_z, want.out_z);
            if (rsp_word.divide_error !== want.divide_error)
               report("divide_error", 32'(rsp_word.divide_error),
                      32'(want.divide_error));
         end
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("point_view_projection: mismatch");
         $finish;
      end
   end

   // send one word; hold start high into the next word when no gap is drawn
   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) gap = 0;
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_words.push_back(project_word(w));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_coef(input int unsigned idx, input logic [31:0] value);
      req_type w;
      w = '0;
      w.opcode = OP_WRITE;
      w.coef_index = idx[4:0];
      w.coef_value = value;
      send_word(w);
   endtask

   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z);
      req_type w;
      w = '0;
      w.opcode = OP_PROJECT;
      w.point_x = x;
      w.point_y = y;
      w.point_z = z;
      w.coef_index = 5'($urandom);
      w.coef_value = $urandom;
      send_word(w);
   endtask

   // drop start and wait until every expected word has come
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_words.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // APB write: setup then access cycle; only while the block is idle
   task automatic csr_write(input logic index, input logic [31:0] value);
      settle();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == CSR_MODE) view_mode = value[1:0];
      else focus = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
   endfunction

   function automatic logic [31:0] rand_coef();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
   endfunction

   task automatic restore_identity();
      int unsigned i;
      for (i = 0; i < STORE_DEPTH; i++) begin
         if ((i < PROJ_BASE && i % 5 == 0 && i < 11) ||
             (i >= PROJ_BASE && (i - PROJ_BASE) % 5 == 0))
            write_coef(i, ONE_COEF);
         else
            write_coef(i, 32'h0);
      end
   endtask

   // extremes of the point fields with the reset identity store
   task automatic test_reset_identity();
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
   endtask

   // store writes at both ends, ignored indexes, overflowing view rows
   task automatic test_coef_store();
      write_coef(0, 32'h7FFF_FFFF);
      write_coef(3, 32'h8000_0000);
      write_coef(27, 32'h0200_0000);
      write_coef(28, 32'h1234_5678);
      write_coef(31, 32'hFFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h0, 32'h0);
      csr_write(CSR_MODE, 32'd3);
      send_point(32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000);
      restore_identity();
   endtask

   // simplified perspective, focus equal to view z and focus extremes
   task automatic test_perspective();
      csr_write(CSR_MODE, {30'd0, MODE_PERSP});
      csr_write(CSR_FOCUS, 32'h000A_0000);
      send_point(32'h0002_0000, 32'hFFFD_0000, 32'h000A_0000);
      send_point(32'h0, 32'h0, 32'h000A_0000);
      send_point(32'h0002_0000, 32'h0001_0000, 32'h0005_0000);
      csr_write(CSR_FOCUS, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      csr_write(CSR_FOCUS, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF);
   endtask

   // general projection, including w zero
   task automatic test_general();
      csr_write(CSR_MODE, {30'd0, MODE_GENERAL});
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      write_coef(PROJ_BASE + 15, 32'h0);
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
      send_point(32'h0, 32'h0, 32'h0);
      write_coef(PROJ_BASE + 14, 32'hFF00_0000);
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
      restore_identity();
   endtask

   // random store contents and points across several settings
   task automatic test_random(input int unsigned words);
      int unsigned n, phase;
      logic [31:0] fvals [5];
      fvals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000, 32'hFFF0_0000};
      for (phase = 0; phase < 8; phase++) begin
         csr_write(CSR_MODE, phase == 7 ? 32'd3 : 32'(phase % 3));
         csr_write(CSR_FOCUS, phase < 5 ? fvals[phase] : $urandom);
         for (n = 0; n < words / 8; n++) begin
            if ($urandom_range(0, 3) == 0)
               write_coef($urandom_range(0, 31), rand_coef());
            else
               send_point(rand_coord(), rand_coord(), rand_coord());
         end
         if (phase == 3) restore_identity();
      end
   endtask

   initial begin
      int unsigned i;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatches = 0;
      cycles = 0;
      view_mode = MODE_NONE;
      focus = 32'h0;
      for (i = 0; i < STORE_DEPTH; i++) coef_mem[i] = 32'h0;
      for (i = 0; i < 3; i++) coef_mem[i * 5] = ONE_COEF;
      for (i = 0; i < 4; i++) coef_mem[PROJ_BASE + i * 5] = ONE_COEF;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_identity();
      test_coef_store();
      test_perspective();
      test_general();
      test_random(344);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("point_view_projection: match");
      else
         $display("point_view_projection: mismatch");
      $finish;
   end
endmodule
